// ----- hdl/fltc_pkg.sv -----
// ----------------------------------------------------------------------------
// Floor texture coordinate package
// Shared widths, fixed-point formats, register indexes and the structs that
// travel between the pipeline modules.
// ----------------------------------------------------------------------------
package fltc_pkg;

    // Fixed-point and texture set-up
    localparam int FRAC_BITS  = 16;
    localparam int TEX_WIDTH  = 64;
    localparam int TEX_HEIGHT = 64;
    localparam int POS_FRAC   = 16;   // fractional bits of the position
    localparam int DIR_FRAC   = 14;   // fractional bits of the ray directions

    // Field widths
    localparam int SCR_W   = 13;
    localparam int POS_W   = 28;
    localparam int DIR_W   = 16;
    localparam int ROW_W   = 13;
    localparam int COL_W   = 12;
    localparam int TEX_W   = 6;
    localparam int DATA_W  = 28;
    localparam int IDX_W   = 3;

    // Derived datapath widths
    localparam int RD_W      = SCR_W + FRAC_BITS - 1;   // row distance
    localparam int DIV_W     = RD_W + 2;                // divider numerator
    localparam int DEN_W     = 13;                      // divider divisor
    localparam int PROD_W    = RD_W + DIR_W;            // unsigned span product
    localparam int LPROD_W   = RD_W + 1 + DIR_W;        // signed left-ray product
    localparam int TEX_MUL_W = 11;                      // room for a size up to 1024

    // Register indexes
    localparam logic [IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_POS_X         = 3'd2;
    localparam logic [IDX_W-1:0] REG_POS_Y         = 3'd3;
    localparam logic [IDX_W-1:0] REG_LEFT_DIR_X    = 3'd4;
    localparam logic [IDX_W-1:0] REG_LEFT_DIR_Y    = 3'd5;
    localparam logic [IDX_W-1:0] REG_RIGHT_DIR_X   = 3'd6;
    localparam logic [IDX_W-1:0] REG_RIGHT_DIR_Y   = 3'd7;

    // Reset values
    localparam logic [SCR_W-1:0] RST_SCREEN_WIDTH  = 13'd640;
    localparam logic [SCR_W-1:0] RST_SCREEN_HEIGHT = 13'd480;
    localparam logic [POS_W-1:0] RST_POS           = 28'd0;
    localparam logic [DIR_W-1:0] RST_LEFT_DIR_X    = 16'h4000;   //  1.0
    localparam logic [DIR_W-1:0] RST_LEFT_DIR_Y    = 16'hD666;   // -0.65
    localparam logic [DIR_W-1:0] RST_RIGHT_DIR_X   = 16'h4000;   //  1.0
    localparam logic [DIR_W-1:0] RST_RIGHT_DIR_Y   = 16'h299A;   //  0.65

    // Per-axis settings worked out from the raw registers
    typedef struct packed {
        logic                 neg;        // right minus left ray is negative
        logic [DIR_W-1:0]     mag;        // magnitude of right minus left ray
        logic [DIR_W-1:0]     left;       // left ray, signed Q2.14
        logic [FRAC_BITS-1:0] pos_frac;   // fraction of the aligned position
    } axis_t;

    typedef struct packed {
        logic [DEN_W-1:0] den;            // screen width, zero taken as one
        axis_t            x;
        axis_t            y;
    } cfg_t;

    // Sideband that rides through a divider beside the quotient
    typedef struct packed {
        logic [COL_W-1:0]     col;
        logic                 neg;
        logic [FRAC_BITS-1:0] lterm;      // fraction of rowdist * left ray
    } tag_t;

endpackage

// ----- hdl/fltc_cfg.sv -----
// ----------------------------------------------------------------------------
// Floor texture coordinate configuration registers
// Holds the eight settings and registers the per-axis values derived from
// them (ray spread, its sign, the aligned position fraction).
// ----------------------------------------------------------------------------
module fltc_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [fltc_pkg::IDX_W-1:0]  cfg_index,
    input  logic [fltc_pkg::DATA_W-1:0] cfg_data,
    output logic [fltc_pkg::SCR_W-1:0]  height,
    output fltc_pkg::cfg_t              cfg
);

    logic [fltc_pkg::SCR_W-1:0] width_reg;
    logic [fltc_pkg::SCR_W-1:0] height_reg;
    logic [fltc_pkg::POS_W-1:0] pos_x_reg;
    logic [fltc_pkg::POS_W-1:0] pos_y_reg;
    logic [fltc_pkg::DIR_W-1:0] left_x_reg;
    logic [fltc_pkg::DIR_W-1:0] left_y_reg;
    logic [fltc_pkg::DIR_W-1:0] right_x_reg;
    logic [fltc_pkg::DIR_W-1:0] right_y_reg;
    fltc_pkg::cfg_t             cfg_reg;
    fltc_pkg::cfg_t             cfg_next;
    logic                       wr_en;

    // Work out one axis from its position and its two rays
    function automatic fltc_pkg::axis_t make_axis(
        input logic [fltc_pkg::POS_W-1:0] pos,
        input logic [fltc_pkg::DIR_W-1:0] left,
        input logic [fltc_pkg::DIR_W-1:0] right
    );
        logic signed [fltc_pkg::DIR_W:0]                 diff;
        logic signed [fltc_pkg::DIR_W:0]                 ndiff;
        logic [fltc_pkg::POS_W+fltc_pkg::FRAC_BITS-1:0]  pos_ext;
        logic [fltc_pkg::POS_W+fltc_pkg::FRAC_BITS-1:0]  pos_aln;
        fltc_pkg::axis_t                                 ax;
        diff    = $signed({right[fltc_pkg::DIR_W-1], right})
                - $signed({left[fltc_pkg::DIR_W-1], left});
        ndiff   = -diff;
        pos_ext = {pos, {fltc_pkg::FRAC_BITS{1'b0}}};
        pos_aln = pos_ext >> fltc_pkg::POS_FRAC;
        ax.neg      = diff[fltc_pkg::DIR_W];
        ax.mag      = diff[fltc_pkg::DIR_W] ? ndiff[fltc_pkg::DIR_W-1:0]
                                            : diff[fltc_pkg::DIR_W-1:0];
        ax.left     = left;
        ax.pos_frac = pos_aln[fltc_pkg::FRAC_BITS-1:0];
        return ax;
    endfunction

    // Always ready; a write is registered when it is taken
    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid & cfg_ready;

    // Take a configuration word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= fltc_pkg::RST_SCREEN_WIDTH;
            height_reg  <= fltc_pkg::RST_SCREEN_HEIGHT;
            pos_x_reg   <= fltc_pkg::RST_POS;
            pos_y_reg   <= fltc_pkg::RST_POS;
            left_x_reg  <= fltc_pkg::RST_LEFT_DIR_X;
            left_y_reg  <= fltc_pkg::RST_LEFT_DIR_Y;
            right_x_reg <= fltc_pkg::RST_RIGHT_DIR_X;
            right_y_reg <= fltc_pkg::RST_RIGHT_DIR_Y;
        end
        else if (wr_en)
        begin
            case (cfg_index)
                fltc_pkg::REG_SCREEN_WIDTH:  width_reg   <= cfg_data[fltc_pkg::SCR_W-1:0];
                fltc_pkg::REG_SCREEN_HEIGHT: height_reg  <= cfg_data[fltc_pkg::SCR_W-1:0];
                fltc_pkg::REG_POS_X:         pos_x_reg   <= cfg_data[fltc_pkg::POS_W-1:0];
                fltc_pkg::REG_POS_Y:         pos_y_reg   <= cfg_data[fltc_pkg::POS_W-1:0];
                fltc_pkg::REG_LEFT_DIR_X:    left_x_reg  <= cfg_data[fltc_pkg::DIR_W-1:0];
                fltc_pkg::REG_LEFT_DIR_Y:    left_y_reg  <= cfg_data[fltc_pkg::DIR_W-1:0];
                fltc_pkg::REG_RIGHT_DIR_X:   right_x_reg <= cfg_data[fltc_pkg::DIR_W-1:0];
                fltc_pkg::REG_RIGHT_DIR_Y:   right_y_reg <= cfg_data[fltc_pkg::DIR_W-1:0];
                default:                     width_reg   <= width_reg;
            endcase
        end
    end

    // Derive the per-axis settings; an item needs them only many stages in
    always_comb
    begin
        cfg_next.den = (width_reg == '0) ? fltc_pkg::DEN_W'(1) : width_reg;
        cfg_next.x   = make_axis(pos_x_reg, left_x_reg, right_x_reg);
        cfg_next.y   = make_axis(pos_y_reg, left_y_reg, right_y_reg);
    end

    always_ff @(posedge clk)
    begin
        cfg_reg <= cfg_next;
    end

    assign height = height_reg;
    assign cfg    = cfg_reg;

endmodule

// ----- hdl/fltc_div.sv -----
// ----------------------------------------------------------------------------
// Floor texture coordinate pipelined divider
// Unsigned restoring divider, one quotient bit per stage, a new word each
// cycle. A sideband tag travels with every word.
// ----------------------------------------------------------------------------
module fltc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [fltc_pkg::DIV_W-1:0] in_num,
    input  logic [fltc_pkg::DEN_W-1:0] in_den,
    input  fltc_pkg::tag_t             in_tag,
    output logic                       out_valid,
    output logic [fltc_pkg::DIV_W-1:0] out_quo,
    output fltc_pkg::tag_t             out_tag
);

    localparam int STEPS = fltc_pkg::DIV_W;

    logic [STEPS-1:0]               vld_reg;
    logic [fltc_pkg::DEN_W-1:0]     rem_reg  [STEPS];
    logic [fltc_pkg::DEN_W-1:0]     rem_next [STEPS];
    logic [fltc_pkg::DIV_W-1:0]     nq_reg   [STEPS];
    logic [fltc_pkg::DIV_W-1:0]     nq_next  [STEPS];
    logic [fltc_pkg::DEN_W-1:0]     den_reg  [STEPS];
    fltc_pkg::tag_t                 tag_reg  [STEPS];
    logic [fltc_pkg::DEN_W-1:0]     src_rem  [STEPS];
    logic [fltc_pkg::DIV_W-1:0]     src_nq   [STEPS];
    logic [fltc_pkg::DEN_W-1:0]     src_den  [STEPS];
    fltc_pkg::tag_t                 src_tag  [STEPS];
    logic [fltc_pkg::DEN_W:0]       trial    [STEPS];
    logic [fltc_pkg::DEN_W:0]       diff     [STEPS];
    logic [STEPS-1:0]               ge;

    // Feed each stage from the one before it, the first from the ports
    always_comb
    begin
        src_rem[0] = '0;
        src_nq[0]  = in_num;
        src_den[0] = in_den;
        src_tag[0] = in_tag;
        for (int k = 1; k < STEPS; k++)
        begin
            src_rem[k] = rem_reg[k-1];
            src_nq[k]  = nq_reg[k-1];
            src_den[k] = den_reg[k-1];
            src_tag[k] = tag_reg[k-1];
        end
    end

    // Shift in the next numerator bit, subtract where the divisor fits
    always_comb
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            trial[k]    = {src_rem[k], src_nq[k][fltc_pkg::DIV_W-1]};
            diff[k]     = trial[k] - {1'b0, src_den[k]};
            ge[k]       = (trial[k] >= {1'b0, src_den[k]});
            rem_next[k] = ge[k] ? diff[k][fltc_pkg::DEN_W-1:0]
                                : trial[k][fltc_pkg::DEN_W-1:0];
            nq_next[k]  = {src_nq[k][fltc_pkg::DIV_W-2:0], ge[k]};
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[STEPS-2:0], in_valid};
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            rem_reg[k] <= rem_next[k];
            nq_reg[k]  <= nq_next[k];
            den_reg[k] <= src_den[k];
            tag_reg[k] <= src_tag[k];
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign out_quo   = nq_reg[STEPS-1];
    assign out_tag   = tag_reg[STEPS-1];

endmodule

// ----- hdl/fltc_span.sv -----
// ----------------------------------------------------------------------------
// Floor texture coordinate span multiplier
// Scales the ray spread and the left ray by the row distance, one stage,
// and hands the spread products on to the step dividers.
// ----------------------------------------------------------------------------
module fltc_span (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [fltc_pkg::RD_W-1:0]  rowdist,
    input  logic [fltc_pkg::COL_W-1:0] col,
    input  fltc_pkg::cfg_t             cfg,
    output logic                       out_valid,
    output logic [fltc_pkg::DIV_W-1:0] mag_x,
    output logic [fltc_pkg::DIV_W-1:0] mag_y,
    output fltc_pkg::tag_t             tag_x,
    output fltc_pkg::tag_t             tag_y
);

    logic                               vld_reg;
    logic [fltc_pkg::PROD_W-1:0]        pmx;
    logic [fltc_pkg::PROD_W-1:0]        pmy;
    logic signed [fltc_pkg::LPROD_W-1:0] plx;
    logic signed [fltc_pkg::LPROD_W-1:0] ply;
    logic signed [fltc_pkg::LPROD_W-1:0] rd_s;
    logic [fltc_pkg::DIV_W-1:0]         mag_x_reg;
    logic [fltc_pkg::DIV_W-1:0]         mag_y_reg;
    fltc_pkg::tag_t                     tag_x_reg;
    fltc_pkg::tag_t                     tag_y_reg;

    // Row distance times ray spread magnitude
    assign pmx = {{fltc_pkg::DIR_W{1'b0}}, rowdist} * {{fltc_pkg::RD_W{1'b0}}, cfg.x.mag};
    assign pmy = {{fltc_pkg::DIR_W{1'b0}}, rowdist} * {{fltc_pkg::RD_W{1'b0}}, cfg.y.mag};

    // Row distance times left ray, signed
    assign rd_s = $signed({{(fltc_pkg::DIR_W+1){1'b0}}, rowdist});
    assign plx  = rd_s * $signed({{(fltc_pkg::RD_W+1){cfg.x.left[fltc_pkg::DIR_W-1]}},
                                  cfg.x.left});
    assign ply  = rd_s * $signed({{(fltc_pkg::RD_W+1){cfg.y.left[fltc_pkg::DIR_W-1]}},
                                  cfg.y.left});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_valid;
        end
    end

    // Drop the ray fraction; keep only the point fraction of the left term
    always_ff @(posedge clk)
    begin
        mag_x_reg       <= pmx[fltc_pkg::PROD_W-1:fltc_pkg::DIR_FRAC];
        mag_y_reg       <= pmy[fltc_pkg::PROD_W-1:fltc_pkg::DIR_FRAC];
        tag_x_reg.col   <= col;
        tag_x_reg.neg   <= cfg.x.neg;
        tag_x_reg.lterm <= plx[fltc_pkg::DIR_FRAC+fltc_pkg::FRAC_BITS-1:fltc_pkg::DIR_FRAC];
        tag_y_reg.col   <= col;
        tag_y_reg.neg   <= cfg.y.neg;
        tag_y_reg.lterm <= ply[fltc_pkg::DIR_FRAC+fltc_pkg::FRAC_BITS-1:fltc_pkg::DIR_FRAC];
    end

    assign out_valid = vld_reg;
    assign mag_x     = mag_x_reg;
    assign mag_y     = mag_y_reg;
    assign tag_x     = tag_x_reg;
    assign tag_y     = tag_y_reg;

endmodule

// ----- hdl/fltc_point.sv -----
// ----------------------------------------------------------------------------
// Floor texture coordinate point and texel stages
// Signs the row step, adds position, left term and column times step in
// the fractional bits only, then scales the fraction to a texel index.
// ----------------------------------------------------------------------------
module fltc_point (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [fltc_pkg::DIV_W-1:0]     quo_x,
    input  logic [fltc_pkg::DIV_W-1:0]     quo_y,
    input  fltc_pkg::tag_t                 tag_x,
    input  fltc_pkg::tag_t                 tag_y,
    input  fltc_pkg::cfg_t                 cfg,
    output logic                           out_valid,
    output logic [fltc_pkg::TEX_W-1:0]     tex_x,
    output logic [fltc_pkg::TEX_W-1:0]     tex_y
);

    localparam int CS_W = fltc_pkg::COL_W + fltc_pkg::FRAC_BITS;
    localparam int TP_W = fltc_pkg::FRAC_BITS + fltc_pkg::TEX_MUL_W;

    logic [fltc_pkg::FRAC_BITS-1:0] step_x;
    logic [fltc_pkg::FRAC_BITS-1:0] step_y;
    logic [CS_W-1:0]                cs_x;
    logic [CS_W-1:0]                cs_y;
    logic                           a_vld_reg;
    logic [fltc_pkg::FRAC_BITS-1:0] cs_x_reg;
    logic [fltc_pkg::FRAC_BITS-1:0] cs_y_reg;
    logic [fltc_pkg::FRAC_BITS-1:0] ls_x_reg;
    logic [fltc_pkg::FRAC_BITS-1:0] ls_y_reg;
    logic [fltc_pkg::FRAC_BITS-1:0] ls_x_next;
    logic [fltc_pkg::FRAC_BITS-1:0] ls_y_next;
    logic [fltc_pkg::FRAC_BITS-1:0] frac_x;
    logic [fltc_pkg::FRAC_BITS-1:0] frac_y;
    logic [TP_W-1:0]                tp_x;
    logic [TP_W-1:0]                tp_y;
    logic                           b_vld_reg;
    logic [fltc_pkg::TEX_W-1:0]     tex_x_reg;
    logic [fltc_pkg::TEX_W-1:0]     tex_y_reg;

    // Step truncates toward zero, so negate the magnitude quotient
    assign step_x = tag_x.neg ? ('0 - quo_x[fltc_pkg::FRAC_BITS-1:0])
                              : quo_x[fltc_pkg::FRAC_BITS-1:0];
    assign step_y = tag_y.neg ? ('0 - quo_y[fltc_pkg::FRAC_BITS-1:0])
                              : quo_y[fltc_pkg::FRAC_BITS-1:0];

    // Column times step; only the fraction reaches the texel
    assign cs_x = {{fltc_pkg::FRAC_BITS{1'b0}}, tag_x.col} * {{fltc_pkg::COL_W{1'b0}}, step_x};
    assign cs_y = {{fltc_pkg::FRAC_BITS{1'b0}}, tag_y.col} * {{fltc_pkg::COL_W{1'b0}}, step_y};

    assign ls_x_next = tag_x.lterm + cfg.x.pos_frac;
    assign ls_y_next = tag_y.lterm + cfg.y.pos_frac;

    // Final sum wraps by floor, then scale by the texture size
    assign frac_x = cs_x_reg + ls_x_reg;
    assign frac_y = cs_y_reg + ls_y_reg;
    assign tp_x   = {{fltc_pkg::TEX_MUL_W{1'b0}}, frac_x} * TP_W'(fltc_pkg::TEX_WIDTH);
    assign tp_y   = {{fltc_pkg::TEX_MUL_W{1'b0}}, frac_y} * TP_W'(fltc_pkg::TEX_HEIGHT);

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
        end
    end

    // Hold the partial sums, then the texel words
    always_ff @(posedge clk)
    begin
        cs_x_reg  <= cs_x[fltc_pkg::FRAC_BITS-1:0];
        cs_y_reg  <= cs_y[fltc_pkg::FRAC_BITS-1:0];
        ls_x_reg  <= ls_x_next;
        ls_y_reg  <= ls_y_next;
        tex_x_reg <= tp_x[fltc_pkg::FRAC_BITS+fltc_pkg::TEX_W-1:fltc_pkg::FRAC_BITS];
        tex_y_reg <= tp_y[fltc_pkg::FRAC_BITS+fltc_pkg::TEX_W-1:fltc_pkg::FRAC_BITS];
    end

    assign out_valid = b_vld_reg;
    assign tex_x     = tex_x_reg;
    assign tex_y     = tex_y_reg;

endmodule

// ----- hdl/floor_texture_coordinate_top.sv -----
// ----------------------------------------------------------------------------
// Floor texture coordinate unit
// Maps a floor pixel (row offset below the horizon, screen column) to the
// texel coordinates of the floor texture under it.
// ----------------------------------------------------------------------------
// Use:
//   Raise start with row_offset and column; the word is taken at the clock
//   edge where start is high and busy low. busy stays low: a new pixel may
//   enter every cycle, back to back, with no gaps needed.
//   Each pixel returns tex_x and tex_y, shown for one cycle with done high,
//   in the order the pixels went in. The receiver cannot hold results off
//   and nothing in the block waits on it. The path runs through two
//   30-stage dividers in turn (row distance, then the row steps, one quotient
//   bit per stage), one multiplier stage and two point and texel stages.
//   Sustained rate is one pixel per clock.
//   Settings go over cfg_valid/cfg_ready with cfg_index and cfg_data; the
//   channel is always ready. The user must write it only while no pixel is
//   in flight; the block itself does not enforce this. Reset clears every
//   valid bit in the pipeline and loads the default screen size, position and view rays.
// ----------------------------------------------------------------------------
module floor_texture_coordinate_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [fltc_pkg::ROW_W-1:0]  row_offset,
    input  logic [fltc_pkg::COL_W-1:0]  column,
    output logic                        done,
    output logic [fltc_pkg::TEX_W-1:0]  tex_x,
    output logic [fltc_pkg::TEX_W-1:0]  tex_y,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [fltc_pkg::IDX_W-1:0]  cfg_index,
    input  logic [fltc_pkg::DATA_W-1:0] cfg_data
);

    logic [fltc_pkg::SCR_W-1:0] height;
    fltc_pkg::cfg_t             cfg;
    logic                       in_take;
    logic [fltc_pkg::DIV_W-1:0] rd_num;
    logic [fltc_pkg::DEN_W-1:0] rd_den;
    fltc_pkg::tag_t             rd_tag;
    logic                       rd_valid;
    logic [fltc_pkg::DIV_W-1:0] rd_quo;
    fltc_pkg::tag_t             rd_tag_out;
    logic                       sp_valid;
    logic [fltc_pkg::DIV_W-1:0] sp_mag_x;
    logic [fltc_pkg::DIV_W-1:0] sp_mag_y;
    fltc_pkg::tag_t             sp_tag_x;
    fltc_pkg::tag_t             sp_tag_y;
    logic                       st_valid_x;
    logic                       st_valid_y;
    logic [fltc_pkg::DIV_W-1:0] st_quo_x;
    logic [fltc_pkg::DIV_W-1:0] st_quo_y;
    fltc_pkg::tag_t             st_tag_x;
    fltc_pkg::tag_t             st_tag_y;
    logic                       st_valid;

    // The pipeline never stalls
    assign busy    = 1'b0;
    assign in_take = start & ~busy;

    fltc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .height    (height),
        .cfg       (cfg)
    );

    // Row distance: half height in point fraction over the row offset
    assign rd_num       = {2'b00, height, {(fltc_pkg::FRAC_BITS-1){1'b0}}};
    assign rd_den       = (row_offset == '0) ? fltc_pkg::DEN_W'(1) : row_offset;
    assign rd_tag.col   = column;
    assign rd_tag.neg   = 1'b0;
    assign rd_tag.lterm = '0;

    fltc_div u_div_rd (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_take),
        .in_num    (rd_num),
        .in_den    (rd_den),
        .in_tag    (rd_tag),
        .out_valid (rd_valid),
        .out_quo   (rd_quo),
        .out_tag   (rd_tag_out)
    );

    fltc_span u_span (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_valid),
        .rowdist   (rd_quo[fltc_pkg::RD_W-1:0]),
        .col       (rd_tag_out.col),
        .cfg       (cfg),
        .out_valid (sp_valid),
        .mag_x     (sp_mag_x),
        .mag_y     (sp_mag_y),
        .tag_x     (sp_tag_x),
        .tag_y     (sp_tag_y)
    );

    // Row steps: spread product over the screen width, one divider per axis
    fltc_div u_div_sx (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sp_valid),
        .in_num    (sp_mag_x),
        .in_den    (cfg.den),
        .in_tag    (sp_tag_x),
        .out_valid (st_valid_x),
        .out_quo   (st_quo_x),
        .out_tag   (st_tag_x)
    );

    fltc_div u_div_sy (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sp_valid),
        .in_num    (sp_mag_y),
        .in_den    (cfg.den),
        .in_tag    (sp_tag_y),
        .out_valid (st_valid_y),
        .out_quo   (st_quo_y),
        .out_tag   (st_tag_y)
    );

    // Both step dividers run in lock step
    assign st_valid = st_valid_x & st_valid_y;

    fltc_point u_point (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (st_valid),
        .quo_x     (st_quo_x),
        .quo_y     (st_quo_y),
        .tag_x     (st_tag_x),
        .tag_y     (st_tag_y),
        .cfg       (cfg),
        .out_valid (done),
        .tex_x     (tex_x),
        .tex_y     (tex_y)
    );

endmodule
